// ===== src/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Shared types, codes and constants for the sender controller and datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int BYTES_PER_BEAT = 4;
    localparam int SUM_BEATS = PAYLOAD_BYTES / BYTES_PER_BEAT;
    localparam int BEAT_W = 3;
    localparam int SUM_W = 13;
    localparam int SEQ_W = 31;
    localparam int PAY_W = PAYLOAD_BYTES * 8;
    localparam int SLOT_W = SEQ_W + 32 + PAY_W;
    localparam logic [31:0] NO_ACK = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_MSG     = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [2:0] KIND_SENT    = 3'd0;
    localparam logic [2:0] KIND_REFUSED = 3'd1;
    localparam logic [2:0] KIND_NEW_ACK = 3'd2;
    localparam logic [2:0] KIND_DUP_ACK = 3'd3;
    localparam logic [2:0] KIND_CORRUPT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SUM,
        ST_FINISH,
        ST_RD,
        ST_EMIT
    } gbn_state_t;

    typedef struct packed {
        logic capture;
        logic sum_step;
        logic finish;
        logic refuse;
        logic rd_issue;
        logic rd_emit;
    } gbn_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       resend_last;
    } gbn_stat_t;

endpackage

// ===== src/go_back_n_sender_unit.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender unit
// Builds, stores and resends packets of a sliding window and handles acks.
//
//   Channel   Handshake          Ports
//   command   start / busy       opcode, packet_seq, packet_ack, packet_check,
//                                payload_lo, payload_mid, payload_hi
//   result    valid (strobe)     kind, out_seq, out_check, out_payload_lo,
//                                out_payload_mid, out_payload_hi,
//                                timer_start, timer_stop, last
//
// A message or ack item steps through capture, decode, five beats of the
// four-byte checksum adder and a build step; a refused message ends after decode.
// A timeout item walks the held packets, with a ring RAM read and an emit for each.
// Each result is shown for one cycle; results are never held back.
// After reset the window is empty and the block is ready at once.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit #(
    parameter int WINDOW = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic signed [31:0]        packet_seq,
    input  logic signed [31:0]        packet_ack,
    input  logic signed [31:0]        packet_check,
    input  logic [63:0]               payload_lo,
    input  logic [63:0]               payload_mid,
    input  logic [31:0]               payload_hi,
    output logic                      valid,
    output logic [2:0]                kind,
    output logic [gbn_pkg::SEQ_W-1:0] out_seq,
    output logic signed [31:0]        out_check,
    output logic [63:0]               out_payload_lo,
    output logic [63:0]               out_payload_mid,
    output logic [31:0]               out_payload_hi,
    output logic                      timer_start,
    output logic                      timer_stop,
    output logic                      last
);
    import gbn_pkg::*;

    gbn_cmd_t  cmd;
    gbn_stat_t stat;

    gbn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    gbn_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .opcode          (opcode),
        .packet_seq      (packet_seq),
        .packet_ack      (packet_ack),
        .packet_check    (packet_check),
        .payload_lo      (payload_lo),
        .payload_mid     (payload_mid),
        .payload_hi      (payload_hi),
        .valid           (valid),
        .kind            (kind),
        .out_seq         (out_seq),
        .out_check       (out_check),
        .out_payload_lo  (out_payload_lo),
        .out_payload_mid (out_payload_mid),
        .out_payload_hi  (out_payload_hi),
        .timer_start     (timer_start),
        .timer_stop      (timer_stop),
        .last            (last)
    );

endmodule

// ===== src/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender controller
// Sequences capture, checksum beats, packet build and the resend walk.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gbn_pkg::gbn_stat_t stat,
    output gbn_pkg::gbn_cmd_t  cmd,
    output logic              busy
);
    import gbn_pkg::*;

    gbn_state_t        state_reg, state_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            beat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            beat_reg  <= beat_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        beat_next  = beat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                beat_next = '0;
                case (stat.op)
                    OP_MSG:     state_next = stat.full ? ST_IDLE : ST_SUM;
                    OP_ACK:     state_next = ST_SUM;
                    OP_TIMEOUT: state_next = stat.empty ? ST_IDLE : ST_RD;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_SUM:
            begin
                beat_next = beat_reg + BEAT_W'(1);
                if (beat_reg == BEAT_W'(SUM_BEATS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            ST_RD:     state_next = ST_EMIT;
            ST_EMIT:   state_next = stat.resend_last ? ST_IDLE : ST_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:     cmd.capture  = start;
            ST_DISPATCH: cmd.refuse   = (stat.op == OP_MSG) && stat.full;
            ST_SUM:      cmd.sum_step = 1'b1;
            ST_FINISH:   cmd.finish   = 1'b1;
            ST_RD:       cmd.rd_issue = 1'b1;
            ST_EMIT:     cmd.rd_emit  = 1'b1;
            default:     cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== src/gbn_dp.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender datapath
// Window registers, checksum accumulator, packet ring and result register.
// ----------------------------------------------------------------------------
module gbn_dp #(
    parameter int WINDOW = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gbn_pkg::gbn_cmd_t         cmd,
    output gbn_pkg::gbn_stat_t        stat,
    input  logic [1:0]                opcode,
    input  logic signed [31:0]        packet_seq,
    input  logic signed [31:0]        packet_ack,
    input  logic signed [31:0]        packet_check,
    input  logic [63:0]               payload_lo,
    input  logic [63:0]               payload_mid,
    input  logic [31:0]               payload_hi,
    output logic                      valid,
    output logic [2:0]                kind,
    output logic [gbn_pkg::SEQ_W-1:0] out_seq,
    output logic signed [31:0]        out_check,
    output logic [63:0]               out_payload_lo,
    output logic [63:0]               out_payload_mid,
    output logic [31:0]               out_payload_hi,
    output logic                      timer_start,
    output logic                      timer_stop,
    output logic                      last
);
    import gbn_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PW = CW + 1;

    logic [1:0]        op_reg;
    logic [31:0]       pseq_reg, pack_reg, pchk_reg;
    logic [PAY_W-1:0]  pay_reg, shift_reg;
    logic [SUM_W-1:0]  acc_reg;

    logic [SW-1:0]     head_reg, head_next;
    logic [CW-1:0]     held_reg, held_next;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  nseq_reg, nseq_next;
    logic [SW-1:0]     rd_slot_reg, rd_slot_next;
    logic [CW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic              valid_reg, valid_next;

    logic [2:0]        kind_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [31:0]       check_reg;
    logic [PAY_W-1:0]  opay_reg;
    logic              tstart_reg, tstop_reg, last_reg;

    logic [SUM_W-1:0]  beat_sum;
    logic [PW-1:0]     wr_sum, ack_sum;
    logic [SW-1:0]     wr_slot, ack_head, rd_slot_inc;
    logic [31:0]       msg_check, ack_check;
    logic [SEQ_W-1:0]  ack_dist;
    logic              ack_ok, ack_new;
    logic [CW-1:0]     ack_n, ack_held;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_wdata, ram_rdata;

    assign beat_sum = acc_reg + SUM_W'(shift_reg[7:0]) + SUM_W'(shift_reg[15:8])
                      + SUM_W'(shift_reg[23:16]) + SUM_W'(shift_reg[31:24]);

    assign wr_sum  = PW'(head_reg) + PW'(held_reg);
    assign wr_slot = (wr_sum >= PW'(WINDOW)) ? SW'(wr_sum - PW'(WINDOW)) : SW'(wr_sum);

    assign msg_check = {1'b0, nseq_reg} + NO_ACK + 32'(acc_reg);
    assign ack_check = pseq_reg + pack_reg + 32'(acc_reg);
    assign ack_ok    = (ack_check == pchk_reg);
    assign ack_dist  = pack_reg[SEQ_W-1:0] - base_reg;
    assign ack_new   = ack_ok && !pack_reg[31] && (ack_dist < SEQ_W'(held_reg));
    assign ack_n     = ack_dist[CW-1:0] + CW'(1);
    assign ack_sum   = PW'(head_reg) + PW'(ack_n);
    assign ack_head  = (ack_sum >= PW'(WINDOW)) ? SW'(ack_sum - PW'(WINDOW)) : SW'(ack_sum);
    assign ack_held  = held_reg - ack_n;

    assign rd_slot_inc = (rd_slot_reg == SW'(WINDOW - 1)) ? '0 : rd_slot_reg + SW'(1);

    assign ram_we    = cmd.finish && (op_reg == OP_MSG);
    assign ram_wdata = {nseq_reg, msg_check, pay_reg};

    gbn_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_slot),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (rd_slot_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_next    = head_reg;
        held_next    = held_reg;
        base_next    = base_reg;
        nseq_next    = nseq_reg;
        rd_slot_next = rd_slot_reg;
        rd_cnt_next  = rd_cnt_reg;
        valid_next   = 1'b0;
        if (cmd.capture)
        begin
            rd_slot_next = head_reg;
            rd_cnt_next  = '0;
        end
        if (cmd.refuse)
        begin
            valid_next = 1'b1;
        end
        if (cmd.finish)
        begin
            valid_next = 1'b1;
            if (op_reg == OP_MSG)
            begin
                held_next = held_reg + CW'(1);
                nseq_next = nseq_reg + SEQ_W'(1);
            end
            else if (ack_new)
            begin
                head_next = ack_head;
                held_next = ack_held;
                base_next = pack_reg[SEQ_W-1:0] + SEQ_W'(1);
            end
        end
        if (cmd.rd_emit)
        begin
            valid_next   = 1'b1;
            rd_slot_next = rd_slot_inc;
            rd_cnt_next  = rd_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            held_reg    <= '0;
            base_reg    <= '0;
            nseq_reg    <= '0;
            rd_slot_reg <= '0;
            rd_cnt_reg  <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            held_reg    <= held_next;
            base_reg    <= base_next;
            nseq_reg    <= nseq_next;
            rd_slot_reg <= rd_slot_next;
            rd_cnt_reg  <= rd_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            pseq_reg  <= $unsigned(packet_seq);
            pack_reg  <= $unsigned(packet_ack);
            pchk_reg  <= $unsigned(packet_check);
            pay_reg   <= {payload_hi, payload_mid, payload_lo};
            shift_reg <= {payload_hi, payload_mid, payload_lo};
            acc_reg   <= '0;
        end
        else if (cmd.sum_step)
        begin
            acc_reg   <= beat_sum;
            shift_reg <= {32'd0, shift_reg[PAY_W-1:32]};
        end

        if (cmd.refuse || cmd.finish || cmd.rd_emit)
        begin
            kind_reg   <= KIND_REFUSED;
            seq_reg    <= '0;
            check_reg  <= '0;
            opay_reg   <= '0;
            tstart_reg <= 1'b0;
            tstop_reg  <= 1'b0;
            last_reg   <= 1'b1;
            if (cmd.finish && (op_reg == OP_MSG))
            begin
                kind_reg   <= KIND_SENT;
                seq_reg    <= nseq_reg;
                check_reg  <= msg_check;
                opay_reg   <= pay_reg;
                tstart_reg <= (held_reg == '0);
            end
            else if (cmd.finish)
            begin
                if (!ack_ok)
                begin
                    kind_reg <= KIND_CORRUPT;
                end
                else if (!ack_new)
                begin
                    kind_reg <= KIND_DUP_ACK;
                end
                else
                begin
                    kind_reg   <= KIND_NEW_ACK;
                    tstart_reg <= (ack_held != '0);
                    tstop_reg  <= 1'b1;
                end
            end
            else if (cmd.rd_emit)
            begin
                kind_reg   <= KIND_SENT;
                seq_reg    <= ram_rdata[SLOT_W-1 -: SEQ_W];
                check_reg  <= ram_rdata[PAY_W +: 32];
                opay_reg   <= ram_rdata[PAY_W-1:0];
                tstart_reg <= (rd_cnt_reg == '0);
                last_reg   <= stat.resend_last;
            end
        end
    end

    assign stat.op          = op_reg;
    assign stat.full        = (held_reg == CW'(WINDOW));
    assign stat.empty       = (held_reg == '0);
    assign stat.resend_last = ((rd_cnt_reg + CW'(1)) == held_reg);

    assign valid           = valid_reg;
    assign kind            = kind_reg;
    assign out_seq         = seq_reg;
    assign out_check       = $signed(check_reg);
    assign out_payload_lo  = opay_reg[63:0];
    assign out_payload_mid = opay_reg[127:64];
    assign out_payload_hi  = opay_reg[159:128];
    assign timer_start     = tstart_reg;
    assign timer_stop      = tstop_reg;
    assign last            = last_reg;

endmodule

// ===== src/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender checker
// Port-level properties of the sender, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      valid,
    input logic [2:0]                kind,
    input logic [gbn_pkg::SEQ_W-1:0] out_seq,
    input logic signed [31:0]        out_check,
    input logic                      timer_stop,
    input logic                      last
);
    import gbn_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted item did not make the block busy.");

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("Two results in consecutive cycles.");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind != KIND_SENT) |-> last && (out_seq == '0) && (out_check == 32'sd0))
        else $error("Status result is not a single zeroed item.");

    a_stop_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        valid && timer_stop |-> (kind == KIND_NEW_ACK))
        else $error("Timer stop outside a new ack.");

endmodule

bind go_back_n_sender_unit gbn_checker u_gbn_checker (.*);
